[rtl/core/ranger_pkg.sv]
// Shared types and constants for the ultrasonic ranger controller.
package ranger_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_TEMPERATURE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRE_LOW     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_LOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LISTEN      = 3'd5;

    localparam int CFG_DATA_W = 16;
    localparam int COUNT_W    = 16;
    localparam int SPEED_W    = 12;
    localparam int PROD_W     = SPEED_W + COUNT_W;
    localparam int DIST_W     = 17;

    // Speed of sound in 0.1 m/s is SPEED_BASE + SPEED_PER_C * temperature.
    localparam logic signed [12:0] SPEED_BASE  = 13'sd3315;
    localparam logic signed [12:0] SPEED_PER_C = 13'sd6;

    // Division by 2000 is a shift by 4 and a reciprocal multiply for 125.
    localparam int DIV_PRE_SHIFT = 4;
    localparam int RECIP_W       = 25;
    localparam int RECIP_SHIFT   = 31;
    localparam logic [RECIP_W-1:0] RECIP_125 = 25'd17179870;

    localparam logic [DIST_W-1:0] DIST_MAX = 17'd131071;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PRE,
        PH_TRIG,
        PH_HOLD,
        PH_REL,
        PH_LISTEN
    } phase_t;

    typedef struct packed {
        logic signed [7:0] temperature_c;
        logic [15:0]       pre_low_us;
        logic [7:0]        trigger_high_us;
        logic [15:0]       hold_low_us;
        logic [15:0]       release_us;
        logic [15:0]       listen_us;
    } cfg_t;

    typedef struct packed {
        logic drive_enable;
        logic drive_level;
        logic busy_res;
        logic done_res;
    } flags_t;

endpackage

[rtl/core/ranger_seq.sv]
// Pin sequencer and echo timer: advances one microsecond per accepted word.
module ranger_seq #(
    parameter int COUNT_UNIT_US = 10
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic                          start_req,
    input  logic                          echo_level,
    input  ranger_pkg::cfg_t              cfg,
    output ranger_pkg::flags_t            flags,
    output logic [ranger_pkg::COUNT_W-1:0] captured_count
);
    import ranger_pkg::*;

    localparam int DIV_W = $clog2(COUNT_UNIT_US + 1);

    phase_t               phase_reg, phase_next, phase_eff;
    logic [15:0]          timer_reg, timer_next, timer_start, timer_inc, phase_len;
    logic [DIV_W-1:0]     div_reg, div_next, div_inc;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [COUNT_W-1:0]   capt_reg, capt_next;
    logic                 echo_prev_reg;
    logic [3:0]           nonzero;
    logic                 phase_end;

    // First phase at or after p (up to listen) whose length is not zero.
    function automatic phase_t skip_empty(phase_t p, logic [3:0] nz);
        phase_t r;
        r = PH_LISTEN;
        if ((p == PH_PRE || p == PH_TRIG || p == PH_HOLD || p == PH_REL) && nz[3]) r = PH_REL;
        if ((p == PH_PRE || p == PH_TRIG || p == PH_HOLD) && nz[2]) r = PH_HOLD;
        if ((p == PH_PRE || p == PH_TRIG) && nz[1]) r = PH_TRIG;
        if (p == PH_PRE && nz[0]) r = PH_PRE;
        return r;
    endfunction

    assign nonzero = {cfg.release_us != '0, cfg.hold_low_us != '0,
                      cfg.trigger_high_us != '0, cfg.pre_low_us != '0};

    // Phase in force for this tick, after a start request out of idle.
    always_comb begin
        phase_eff   = phase_reg;
        timer_start = timer_reg;
        if (phase_reg == PH_IDLE && start_req) begin
            phase_eff   = skip_empty(PH_PRE, nonzero);
            timer_start = '0;
        end
    end

    always_comb begin
        case (phase_eff)
            PH_PRE:    phase_len = cfg.pre_low_us;
            PH_TRIG:   phase_len = {8'd0, cfg.trigger_high_us};
            PH_HOLD:   phase_len = cfg.hold_low_us;
            PH_REL:    phase_len = cfg.release_us;
            PH_LISTEN: phase_len = (cfg.listen_us == '0) ? 16'd1 : cfg.listen_us;
            default:   phase_len = '0;
        endcase
    end

    assign timer_inc = timer_start + 16'd1;
    assign phase_end = (phase_eff != PH_IDLE) &&
                       ((timer_inc >= phase_len) || (timer_inc == '0));
    assign div_inc   = div_reg + DIV_W'(1);

    // Next state.
    always_comb begin
        phase_next = phase_eff;
        timer_next = timer_start;
        div_next   = div_reg;
        count_next = count_reg;
        capt_next  = capt_reg;
        if (phase_eff == PH_LISTEN) begin
            if (echo_level && !echo_prev_reg) begin
                count_next = '0;
                div_next   = '0;
            end else begin
                if (!echo_level && echo_prev_reg) begin
                    capt_next = count_reg;
                end
                if (div_inc >= DIV_W'(COUNT_UNIT_US)) begin
                    div_next   = '0;
                    count_next = count_reg + COUNT_W'(1);
                end else begin
                    div_next = div_inc;
                end
            end
        end
        if (phase_eff != PH_IDLE) begin
            if (phase_end) begin
                timer_next = '0;
                case (phase_eff)
                    PH_PRE:  phase_next = skip_empty(PH_TRIG, nonzero);
                    PH_TRIG: phase_next = skip_empty(PH_HOLD, nonzero);
                    PH_HOLD: phase_next = skip_empty(PH_REL, nonzero);
                    PH_REL:  phase_next = PH_LISTEN;
                    default: phase_next = PH_IDLE;
                endcase
            end else begin
                timer_next = timer_inc;
            end
        end
    end

    // Outputs for this tick.
    always_comb begin
        flags.busy_res     = phase_eff != PH_IDLE;
        flags.drive_enable = (phase_eff == PH_PRE) || (phase_eff == PH_TRIG) ||
                             (phase_eff == PH_HOLD);
        flags.drive_level  = phase_eff == PH_TRIG;
        flags.done_res     = phase_end && (phase_eff == PH_LISTEN);
        captured_count     = capt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            timer_reg     <= '0;
            div_reg       <= '0;
            count_reg     <= '0;
            capt_reg      <= '0;
            echo_prev_reg <= 1'b0;
        end else if (step) begin
            phase_reg     <= phase_next;
            timer_reg     <= timer_next;
            div_reg       <= div_next;
            count_reg     <= count_next;
            capt_reg      <= capt_next;
            echo_prev_reg <= echo_level;
        end
    end

endmodule

[rtl/core/ranger_dist.sv]
// Two-stage distance datapath: speed times count, then division by 2000.
module ranger_dist (
    input  logic                           aclk,
    input  logic                           enable,
    input  logic                           done_res,
    input  logic signed [7:0]              temperature_c,
    input  logic [ranger_pkg::COUNT_W-1:0] captured_count,
    output logic [ranger_pkg::DIST_W-1:0]  distance_mm
);
    import ranger_pkg::*;

    localparam int X_W = PROD_W - DIV_PRE_SHIFT;
    localparam int T_W = X_W + RECIP_W;
    localparam int Q_W = T_W - RECIP_SHIFT;

    logic signed [12:0]  speed_s;
    logic [SPEED_W-1:0]  speed;
    logic [PROD_W-1:0]   prod_reg;
    logic                done_reg;
    logic [X_W-1:0]      x;
    logic [T_W-1:0]      t;
    logic [Q_W-1:0]      q;
    logic [DIST_W-1:0]   dist_next, dist_reg;

    // Always positive over the whole signed 8-bit temperature range.
    assign speed_s = SPEED_BASE + 13'(temperature_c) * SPEED_PER_C;
    assign speed   = speed_s[SPEED_W-1:0];

    assign x = prod_reg[PROD_W-1:DIV_PRE_SHIFT];
    assign t = T_W'(x) * T_W'(RECIP_125);
    assign q = t[T_W-1:RECIP_SHIFT];

    always_comb begin
        if (!done_reg) begin
            dist_next = '0;
        end else if (q > Q_W'(DIST_MAX)) begin
            dist_next = DIST_MAX;
        end else begin
            dist_next = q[DIST_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (enable) begin
            prod_reg <= PROD_W'(speed) * PROD_W'(captured_count);
            done_reg <= done_res;
            dist_reg <= dist_next;
        end
    end

    assign distance_mm = dist_reg;

endmodule

[rtl/core/ultrasonic_ranger_controller.sv]
// Ultrasonic ranger controller top level: config registers, handshake and pipeline.
// Each accepted word steps the sequencer once and yields a result word through
// a_valid_reg, then out_valid_reg. Throughput: one word per cycle unless m_tready
// stalls. Multiply and divide by 2000 are two registered stages past the sequencer.
// Reset: aresetn is synchronous and active low; it returns the sequencer to idle,
// empties the pipeline and loads the register defaults.
module ultrasonic_ranger_controller #(
    parameter int COUNT_UNIT_US = 10
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // start_req, echo_level
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // drive_enable, drive_level, busy_res, done_res, distance_mm[16:0]
    output logic [23:0]                       m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ranger_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ranger_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ranger_pkg::*;

    cfg_t                cfg_reg;
    logic                advance, accept;
    logic                a_valid_reg, out_valid_reg;
    flags_t              seq_flags, a_flags_reg, out_flags_reg;
    logic [COUNT_W-1:0]  capt_count;
    logic [DIST_W-1:0]   distance;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.temperature_c   <= 8'sd20;
            cfg_reg.pre_low_us      <= 16'd500;
            cfg_reg.trigger_high_us <= 8'd5;
            cfg_reg.hold_low_us     <= 16'd100;
            cfg_reg.release_us      <= 16'd100;
            cfg_reg.listen_us       <= 16'd10000;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_TEMPERATURE: cfg_reg.temperature_c   <= cfg_data[7:0];
                REG_PRE_LOW:     cfg_reg.pre_low_us      <= cfg_data;
                REG_TRIGGER:     cfg_reg.trigger_high_us <= cfg_data[7:0];
                REG_HOLD_LOW:    cfg_reg.hold_low_us     <= cfg_data;
                REG_RELEASE:     cfg_reg.release_us      <= cfg_data;
                REG_LISTEN:      cfg_reg.listen_us       <= cfg_data;
                default: ;
            endcase
        end
    end

    // The whole pipeline moves whenever the output register is free or drained.
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance;
    assign accept   = s_tvalid && advance;

    ranger_seq #(
        .COUNT_UNIT_US(COUNT_UNIT_US)
    ) u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (accept),
        .start_req      (s_tdata[0]),
        .echo_level     (s_tdata[1]),
        .cfg            (cfg_reg),
        .flags          (seq_flags),
        .captured_count (capt_count)
    );

    ranger_dist u_dist (
        .aclk           (aclk),
        .enable         (advance),
        .done_res       (seq_flags.done_res),
        .temperature_c  (cfg_reg.temperature_c),
        .captured_count (capt_count),
        .distance_mm    (distance)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            a_valid_reg   <= accept;
            out_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            a_flags_reg   <= seq_flags;
            out_flags_reg <= a_flags_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, distance, out_flags_reg.done_res, out_flags_reg.busy_res,
                       out_flags_reg.drive_level, out_flags_reg.drive_enable};

endmodule
